// ===== design/ctlk_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctlk_pkg
// Shared types, codes and CRC8 helpers for the CAN torque command link.
// ----------------------------------------------------------------------------
package ctlk_pkg;

  localparam int COUNTER_BITS = 4;

  localparam logic [7:0]  CRC_INIT     = 8'hFF;
  localparam logic [7:0]  CRC_POLY     = 8'hD5;
  localparam logic [31:0] MAGIC_ENTRY  = 32'hdeadface;
  localparam logic [31:0] MAGIC_SOFT   = 32'h0ab00b1e;
  localparam logic [31:0] MAGIC_BOOT   = 32'h02b00b1e;
  localparam logic [31:0] MAGIC_PARAMS = 32'hca55e77e;

  localparam logic [10:0] ACCEPT_ID_RESET     = 11'h200;
  localparam logic [7:0]  TIMEOUT_LIMIT_RESET = 8'd10;

  // event codes on the input op field
  localparam logic [1:0] OP_FRAME  = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_BUSERR = 2'd2;

  // register map, decoded on paddr[2]
  localparam logic REG_ACCEPT_ID     = 1'b0;
  localparam logic REG_TIMEOUT_LIMIT = 1'b1;

  localparam logic [2:0] FLT_NONE     = 3'd0;
  localparam logic [2:0] FLT_CHECKSUM = 3'd1;
  localparam logic [2:0] FLT_SEND     = 3'd2;
  localparam logic [2:0] FLT_BUSERR   = 3'd3;
  localparam logic [2:0] FLT_STARTUP  = 3'd4;
  localparam logic [2:0] FLT_TIMEOUT  = 3'd5;
  localparam logic [2:0] FLT_INVALID  = 3'd6;

  localparam logic [1:0] REBOOT_NONE = 2'd0;
  localparam logic [1:0] REBOOT_SOFT = 2'd1;
  localparam logic [1:0] REBOOT_BOOT = 2'd2;

  typedef logic [COUNTER_BITS-1:0] cnt_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [10:0] frame_id;
    logic [31:0] payload_low;
    logic [31:0] payload_high;
    logic [11:0] torque_a;
    logic [11:0] torque_b;
    logic        mailbox_free;
  } in_item_t;

  typedef struct packed {
    logic [15:0] torque_request;
    logic [2:0]  fault_code;
    logic        tx_valid;
    logic [47:0] tx_payload;
    logic [1:0]  reboot_request;
    logic        led_level;
  } out_item_t;

  typedef enum logic [2:0] {
    CLS_NOP,
    CLS_FRAME,
    CLS_TICK,
    CLS_BUSERR,
    CLS_REBOOT
  } item_cls_t;

  // classified request handed from front to back
  typedef struct packed {
    item_cls_t   cls;
    logic [1:0]  reboot;
    logic        crc_ok;
    cnt_t        idx;
    logic        en;
    logic [15:0] v0;
    logic        cmd_zero;
    logic [11:0] torque_a;
    logic [11:0] torque_b;
    logic        mailbox_free;
  } cls_item_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] c_in, input logic [7:0] d);
    logic [7:0] c;
    c = c_in ^ d;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // bytes fed from byte 4 down to byte 0; byte 0 in bits 7..0
  function automatic logic [7:0] crc8_five(input logic [39:0] b);
    logic [7:0] c;
    c = CRC_INIT;
    for (int i = 4; i >= 0; i--) begin
      c = crc8_byte(c, b[i*8 +: 8]);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/ctlk_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctlk_front
// Classifies incoming events: ID filter, reboot magic, frame CRC and fields.
// ----------------------------------------------------------------------------
module ctlk_front (
  input  wire ctlk_pkg::in_item_t  in_item,
  input  wire logic [10:0]         accept_id,
  output ctlk_pkg::cls_item_t      cls_item
);
  import ctlk_pkg::*;

  logic [31:0] lo;
  logic [31:0] hi;
  logic        magic_soft;
  logic        magic_boot;

  assign lo = in_item.payload_low;
  assign hi = in_item.payload_high;

  assign magic_soft = (lo == MAGIC_ENTRY) && ((hi == MAGIC_SOFT) || (hi == MAGIC_PARAMS));
  assign magic_boot = (lo == MAGIC_ENTRY) && (hi == MAGIC_BOOT);

  always_comb begin
    cls_item              = '0;
    cls_item.cls          = CLS_NOP;
    cls_item.reboot       = REBOOT_NONE;
    cls_item.crc_ok       = (crc8_five({hi[7:0], lo}) == hi[15:8]);
    cls_item.idx          = hi[COUNTER_BITS-1:0];
    cls_item.en           = hi[7];
    cls_item.v0           = {lo[7:0], lo[15:8]};
    cls_item.cmd_zero     = (lo == 32'd0);
    cls_item.torque_a     = in_item.torque_a;
    cls_item.torque_b     = in_item.torque_b;
    cls_item.mailbox_free = in_item.mailbox_free;
    case (in_item.op)
      OP_FRAME: begin
        if (in_item.frame_id == accept_id) begin
          if (magic_soft) begin
            cls_item.cls    = CLS_REBOOT;
            cls_item.reboot = REBOOT_SOFT;
          end else if (magic_boot) begin
            cls_item.cls    = CLS_REBOOT;
            cls_item.reboot = REBOOT_BOOT;
          end else begin
            cls_item.cls = CLS_FRAME;
          end
        end
      end
      OP_TICK:   cls_item.cls = CLS_TICK;
      OP_BUSERR: cls_item.cls = CLS_BUSERR;
      default:   cls_item.cls = CLS_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/ctlk_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctlk_queue
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module ctlk_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire ctlk_pkg::cls_item_t  wr_item,
  output logic                      full,
  input  wire logic                 pop,
  output ctlk_pkg::cls_item_t       rd_item,
  output logic                      empty
);
  import ctlk_pkg::*;

  cls_item_t  mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rd_item = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt  = wptr_r ^ do_push;
    rptr_nxt  = rptr_r ^ do_pop;
    count_nxt = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

// ===== design/ctlk_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctlk_back
// Applies classified requests to the link state and queues the results.
// ----------------------------------------------------------------------------
module ctlk_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [7:0]           timeout_limit,
  input  wire ctlk_pkg::cls_item_t  req,
  input  wire logic                 req_empty,
  output logic                      req_pop,
  output ctlk_pkg::out_item_t       out_item,
  output logic                      out_empty,
  input  wire logic                 out_pop
);
  import ctlk_pkg::*;

  logic [2:0]  fault_r, fault_nxt;
  logic [15:0] torque_r, torque_nxt;
  logic [7:0]  silence_r, silence_nxt;
  cnt_t        rx_cnt_r, rx_cnt_nxt;
  cnt_t        tx_cnt_r, tx_cnt_nxt;
  logic        led_r, led_nxt;

  out_item_t   oq_r [2];
  logic        oq_wptr_r, oq_rptr_r;
  logic [1:0]  oq_count_r, oq_count_nxt;
  logic        oq_pop;
  out_item_t   res;
  logic [7:0]  st_b4;
  logic [39:0] st_bytes;

  assign req_pop   = !req_empty && (oq_count_r != 2'd2);
  assign out_empty = (oq_count_r == 2'd0);
  assign out_item  = oq_r[oq_rptr_r];
  assign oq_pop    = out_pop && !out_empty;

  // status frame bytes 4..0, byte 0 in bits 7..0
  assign st_b4    = {1'b0, fault_r, 4'b0000} | 8'(tx_cnt_r);
  assign st_bytes = {st_b4, req.torque_b[7:0], 4'b0000, req.torque_b[11:8],
                     req.torque_a[7:0], 4'b0000, req.torque_a[11:8]};

  always_comb begin
    fault_nxt   = fault_r;
    torque_nxt  = torque_r;
    silence_nxt = silence_r;
    rx_cnt_nxt  = rx_cnt_r;
    tx_cnt_nxt  = tx_cnt_r;
    led_nxt     = led_r;
    res         = '0;
    res.reboot_request = REBOOT_NONE;
    case (req.cls)
      CLS_REBOOT: res.reboot_request = req.reboot;
      CLS_FRAME: begin
        if (req.crc_ok) begin
          if (cnt_t'(rx_cnt_r + 1'b1) == req.idx) begin
            if (req.en) begin
              torque_nxt = req.v0;
            end else begin
              fault_nxt  = req.cmd_zero ? FLT_NONE : FLT_INVALID;
              torque_nxt = 16'd0;
            end
            silence_nxt = 8'd0;
          end
          rx_cnt_nxt = req.idx;
        end else begin
          fault_nxt = FLT_CHECKSUM;
        end
      end
      CLS_TICK: begin
        if (req.mailbox_free) begin
          res.tx_valid   = 1'b1;
          res.tx_payload = {crc8_five(st_bytes), st_bytes};
          tx_cnt_nxt     = cnt_t'(tx_cnt_r + 1'b1);
        end else begin
          fault_nxt = FLT_SEND;
        end
        led_nxt = !led_r;
        // timeout wins over a send fault on the same tick
        if (silence_r == timeout_limit) begin
          fault_nxt = FLT_TIMEOUT;
        end else begin
          silence_nxt = silence_r + 8'd1;
        end
      end
      CLS_BUSERR: fault_nxt = FLT_BUSERR;
      default: ;
    endcase
    res.torque_request = torque_nxt;
    res.fault_code     = fault_nxt;
    res.led_level      = led_nxt;
    oq_count_nxt       = oq_count_r + 2'(req_pop) - 2'(oq_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r    <= FLT_STARTUP;
      torque_r   <= 16'd0;
      silence_r  <= 8'd0;
      rx_cnt_r   <= '0;
      tx_cnt_r   <= '0;
      led_r      <= 1'b0;
      oq_wptr_r  <= 1'b0;
      oq_rptr_r  <= 1'b0;
      oq_count_r <= 2'd0;
    end else begin
      if (req_pop) begin
        fault_r   <= fault_nxt;
        torque_r  <= torque_nxt;
        silence_r <= silence_nxt;
        rx_cnt_r  <= rx_cnt_nxt;
        tx_cnt_r  <= tx_cnt_nxt;
        led_r     <= led_nxt;
      end
      oq_wptr_r  <= oq_wptr_r ^ req_pop;
      oq_rptr_r  <= oq_rptr_r ^ oq_pop;
      oq_count_r <= oq_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_pop) begin
      oq_r[oq_wptr_r] <= res;
    end
  end

endmodule
`default_nettype wire

// ===== design/can_torque_command_link_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// can_torque_command_link_core
// CAN command frame supervision (CRC8, rolling counter, timeout) and status
// frame generation, behind queue-style request and result channels.
// ----------------------------------------------------------------------------
// Path: a classified request lands in the request queue, and its back update
//   lands in the result queue; the back stalls while the result queue is full.
// Throughput: one request per cycle, set by the back update, while the result queue has room.
// Reset (rst_n low, synchronous): queues empty, fault = startup, torque,
//   counters and LED zero, accept_id = 0x200, timeout_limit = 10.
// ----------------------------------------------------------------------------
module can_torque_command_link_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  input  wire ctlk_pkg::in_item_t  in_data,
  output logic                     in_full,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output ctlk_pkg::out_item_t      out_data,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [2:0]          cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);
  import ctlk_pkg::*;

  logic [10:0] accept_id_r;
  logic [7:0]  timeout_limit_r;
  logic        cfg_wr;
  cls_item_t   front_item;
  cls_item_t   q_item;
  logic        q_empty;
  logic        q_pop;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accept_id_r     <= ACCEPT_ID_RESET;
      timeout_limit_r <= TIMEOUT_LIMIT_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_ACCEPT_ID:     accept_id_r     <= cfg_pwdata[10:0];
        REG_TIMEOUT_LIMIT: timeout_limit_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_ACCEPT_ID:     cfg_prdata = {21'd0, accept_id_r};
      REG_TIMEOUT_LIMIT: cfg_prdata = {24'd0, timeout_limit_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  ctlk_front u_front (
    .in_item   (in_data),
    .accept_id (accept_id_r),
    .cls_item  (front_item)
  );

  ctlk_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_item (front_item),
    .full    (in_full),
    .pop     (q_pop),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  ctlk_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .timeout_limit (timeout_limit_r),
    .req           (q_item),
    .req_empty     (q_empty),
    .req_pop       (q_pop),
    .out_item      (out_data),
    .out_empty     (out_empty),
    .out_pop       (out_pop)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  a_no_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.tx_valid) |-> (out_data.tx_payload == 48'd0))
    else $error("status payload nonzero without tx_valid");

  a_reboot_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_data.reboot_request != REBOOT_NONE)) |-> !out_data.tx_valid)
    else $error("reboot request together with status frame");

  a_back_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_empty && out_empty) |-> q_pop)
    else $error("back stalled with room in result queue");

endmodule
`default_nettype wire
